// ===== hdl/ims_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ims_pkg;

	// fixed field widths of the request, result and configuration
	localparam int OPC_W  = 2;
	localparam int SITE_W = 10;
	localparam int DIR_W  = 3;
	localparam int SIZE_W = 14;
	localparam int CFG_W  = 4;

	// number of distinct site codes the site field can carry
	localparam int SITE_SPAN = 2 ** SITE_W;

	// directions per site after reset
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	// request codes; any other code only asks for membership
	localparam logic [OPC_W-1:0] OP_ADD    = OPC_W'(0);
	localparam logic [OPC_W-1:0] OP_REMOVE = OPC_W'(1);

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_REDUCE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_CLEAR_KEY,
		ST_FINISH
	} ims_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic reduce_step;
		logic lookup;
		logic update;
		logic clear_key;
		logic publish;
		logic wipe;
	} ims_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic reduce_need;
		logic reduce_last;
		logic remove_now;
		logic out_free;
		logic wipe_last;
	} ims_status_t;

endpackage

`default_nettype wire

// ===== hdl/ims_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ims_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/ims_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ims_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ims_pkg::ims_status_t st,
	output ims_pkg::ims_cmd_t   cmd,
	output logic                in_stall
);

	import ims_pkg::*;

	ims_state_t state_q;
	ims_state_t state_nxt;
	logic       ready;
	logic       take;

	// a new request is taken when idle, or when the finished one leaves
	assign ready = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && st.out_free);
	assign take  = ready && in_valid;
	assign in_stall = !ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_WIPE: begin
				if (st.wipe_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take) begin
					state_nxt = st.reduce_need ? ST_REDUCE : ST_LOOKUP;
				end
			end
			ST_REDUCE: begin
				if (st.reduce_last) begin
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_nxt = st.remove_now ? ST_CLEAR_KEY : ST_FINISH;
			end
			ST_CLEAR_KEY: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (take) begin
					state_nxt = st.reduce_need ? ST_REDUCE : ST_LOOKUP;
				end else if (st.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_WIPE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.capture = take;
		unique case (state_q)
			ST_WIPE:      cmd.wipe        = 1'b1;
			ST_IDLE:      cmd.publish     = 1'b0;
			ST_REDUCE:    cmd.reduce_step = 1'b1;
			ST_LOOKUP:    cmd.lookup      = 1'b1;
			ST_UPDATE:    cmd.update      = 1'b1;
			ST_CLEAR_KEY: cmd.clear_key   = 1'b1;
			ST_FINISH:    cmd.publish     = st.out_free;
			default:      cmd.wipe        = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/ims_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ims_datapath #(
	parameter int MAX_SITES      = 1024,
	parameter int MAX_DIRECTIONS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ims_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic [ims_pkg::OPC_W-1:0]  opcode,
	input  logic [ims_pkg::SITE_W-1:0] site,
	input  logic [ims_pkg::DIR_W-1:0]  direction,
	input  logic                       out_stall,
	input  ims_pkg::ims_cmd_t          cmd,
	output ims_pkg::ims_status_t       st,
	output logic                       out_valid,
	output logic                       was_present,
	output logic                       is_present,
	output logic [ims_pkg::SIZE_W-1:0] set_size,
	output logic                       bad_direction
);

	import ims_pkg::*;

	localparam int KEY_DEPTH = MAX_SITES * MAX_DIRECTIONS;
	localparam int KEY_W     = $clog2(KEY_DEPTH);
	localparam int LEN_W     = $clog2(KEY_DEPTH + 1);
	localparam int DPS_W     = $clog2(MAX_DIRECTIONS + 1);
	localparam int DW        = (DPS_W > CFG_W) ? DPS_W : CFG_W;
	localparam int RAW_W     = $clog2(SITE_SPAN * MAX_DIRECTIONS);
	// compare-subtract steps to fold a raw key below the store depth
	localparam int RED_STEPS =
		$clog2((SITE_SPAN * MAX_DIRECTIONS + KEY_DEPTH - 1) / KEY_DEPTH);

	logic [CFG_W-1:0] cfg_q;
	logic [DW-1:0]    cfg_x;
	logic [DW-1:0]    dps;
	logic             bad_c;
	logic [RAW_W-1:0] raw_c;
	logic [RAW_W-1:0] raw_red;
	logic             red_last;

	logic [OPC_W-1:0] opc_q;
	logic             bad_q;
	logic [RAW_W-1:0] raw_q;
	logic [KEY_W-1:0] key;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_m1;
	logic [KEY_W-1:0] wipe_q;

	logic             slot_we;
	logic [KEY_W-1:0] slot_waddr;
	logic [KEY_W:0]   slot_wdata;
	logic [KEY_W:0]   slot_rd;
	logic             list_we;
	logic [KEY_W-1:0] list_waddr;
	logic [KEY_W-1:0] list_wdata;
	logic [KEY_W-1:0] list_rd;

	logic             was_set;
	logic [KEY_W-1:0] slot_idx;
	logic             add_now;
	logic             rem_now;
	logic             do_add;
	logic             do_rem;

	logic             was_q;
	logic             is_q;
	logic             out_valid_q;
	logic             was_out_q;
	logic             is_out_q;
	logic [SIZE_W-1:0] size_out_q;
	logic             bad_out_q;

	// directions per site register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// key formation; the register value is clamped at the largest direction count
	assign cfg_x = DW'(cfg_q);
	assign dps   = (cfg_x > DW'(MAX_DIRECTIONS)) ? DW'(MAX_DIRECTIONS) : cfg_x;
	assign bad_c = DW'(direction) >= dps;
	assign raw_c = RAW_W'(RAW_W'(site) * RAW_W'(dps) + RAW_W'(direction));

	// fold of the raw key into the store, one compare-subtract a cycle
	generate
		if (RED_STEPS > 0) begin : g_reduce
			localparam logic [RAW_W:0] SUB_INIT =
				(RAW_W + 1)'(KEY_DEPTH * (2 ** (RED_STEPS - 1)));
			logic [RAW_W:0] sub_q;

			always_ff @(posedge clk) begin
				if (cmd.capture) begin
					sub_q <= SUB_INIT;
				end else if (cmd.reduce_step) begin
					sub_q <= sub_q >> 1;
				end
			end

			assign raw_red  = ({1'b0, raw_q} >= sub_q) ?
				RAW_W'({1'b0, raw_q} - sub_q) : raw_q;
			assign red_last = (sub_q == (RAW_W + 1)'(KEY_DEPTH));
			assign st.reduce_need = 1'b1;
		end else begin : g_no_reduce
			assign raw_red  = raw_q;
			assign red_last = 1'b1;
			assign st.reduce_need = 1'b0;
		end
	endgenerate

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opc_q <= opcode;
			bad_q <= bad_c;
			raw_q <= raw_c;
		end else if (cmd.reduce_step) begin
			raw_q <= raw_red;
		end
	end

	assign key    = KEY_W'(raw_q);
	assign len_m1 = len_q - LEN_W'(1);

	// reverse index: valid bit over list slot
	ims_ram #(
		.WIDTH(KEY_W + 1),
		.DEPTH(KEY_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (cmd.lookup),
		.raddr(key),
		.rdata(slot_rd)
	);

	// dense list of present keys
	ims_ram #(
		.WIDTH(KEY_W),
		.DEPTH(KEY_DEPTH)
	) u_list_ram (
		.clk  (clk),
		.we   (list_we),
		.waddr(list_waddr),
		.wdata(list_wdata),
		.re   (cmd.lookup),
		.raddr(len_m1[KEY_W-1:0]),
		.rdata(list_rd)
	);

	// decision on the looked-up entry
	assign was_set  = slot_rd[KEY_W];
	assign slot_idx = slot_rd[KEY_W-1:0];
	assign add_now  = !bad_q && (opc_q == OP_ADD) && !was_set;
	assign rem_now  = !bad_q && (opc_q == OP_REMOVE) && was_set;
	assign do_add   = cmd.update && add_now;
	assign do_rem   = cmd.update && rem_now;

	// reverse index writes: clearing pass, key removal, append, moved entry
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = key;
		slot_wdata = '0;
		if (cmd.wipe) begin
			slot_we    = 1'b1;
			slot_waddr = wipe_q;
		end else if (cmd.clear_key) begin
			slot_we    = 1'b1;
		end else if (do_add) begin
			slot_we    = 1'b1;
			slot_wdata = {1'b1, len_q[KEY_W-1:0]};
		end else if (do_rem) begin
			slot_we    = 1'b1;
			slot_waddr = list_rd;
			slot_wdata = {1'b1, slot_idx};
		end
	end

	// list writes: append at the end, or last entry into the freed slot
	always_comb begin
		list_we    = 1'b0;
		list_waddr = len_q[KEY_W-1:0];
		list_wdata = key;
		if (do_add) begin
			list_we = 1'b1;
		end else if (do_rem) begin
			list_we    = 1'b1;
			list_waddr = slot_idx;
			list_wdata = list_rd;
		end
	end

	// list length and clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			wipe_q <= '0;
		end else begin
			if (do_add) begin
				len_q <= len_q + LEN_W'(1);
			end else if (do_rem) begin
				len_q <= len_m1;
			end
			if (cmd.wipe) begin
				wipe_q <= wipe_q + KEY_W'(1);
			end
		end
	end

	// presence flags of the request
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			was_q <= !bad_q && was_set;
			is_q  <= add_now || (!bad_q && was_set && !rem_now);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			was_out_q  <= was_q;
			is_out_q   <= is_q;
			size_out_q <= SIZE_W'(len_q);
			bad_out_q  <= bad_q;
		end
	end

	assign st.reduce_last = red_last;
	assign st.remove_now  = rem_now;
	assign st.out_free    = !out_valid_q || !out_stall;
	assign st.wipe_last   = (wipe_q == KEY_W'(KEY_DEPTH - 1));

	assign out_valid     = out_valid_q;
	assign was_present   = was_out_q;
	assign is_present    = is_out_q;
	assign set_size      = size_out_q;
	assign bad_direction = bad_out_q;

endmodule

`default_nettype wire

// ===== hdl/indexed_move_set_unit.sv =====
// sequence: a request is captured, its key folded by compare-subtract steps when MAX_SITES is below 1024,
//   then the memories are read and updated (a removal adds a key clearing step) and the result registered
// one request in flight at a time: a new one is taken only when idle or as the last result leaves,
//   since the registered read of the reverse index and list memories is followed by their writes
// reset: list empty, directions per site 4; a clearing pass over all MAX_SITES * MAX_DIRECTIONS
//   reverse index entries (8192 at the defaults) runs with in_stall high
`timescale 1ns / 1ps
`default_nettype none

module indexed_move_set_unit #(
	parameter int MAX_SITES      = 1024,
	parameter int MAX_DIRECTIONS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ims_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ims_pkg::OPC_W-1:0]  opcode,
	input  logic [ims_pkg::SITE_W-1:0] site,
	input  logic [ims_pkg::DIR_W-1:0]  direction,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       was_present,
	output logic                       is_present,
	output logic [ims_pkg::SIZE_W-1:0] set_size,
	output logic                       bad_direction
);

	import ims_pkg::*;

	ims_cmd_t    cmd;
	ims_status_t st;

	// sequencer
	ims_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.st      (st),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	// key formation, memories and result register
	ims_datapath #(
		.MAX_SITES     (MAX_SITES),
		.MAX_DIRECTIONS(MAX_DIRECTIONS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.opcode       (opcode),
		.site         (site),
		.direction    (direction),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.was_present  (was_present),
		.is_present   (is_present),
		.set_size     (set_size),
		.bad_direction(bad_direction)
	);

	// one request in flight at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while another is in flight");

	// a bad direction reports no presence
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_direction) |-> (!was_present && !is_present))
		else $error("bad direction result shows presence");

	// a present move implies a non-empty list
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_present) |-> (set_size != '0))
		else $error("present move with empty list");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import ims_pkg::*;

	localparam int MAX_DIRS = 8;
	localparam int KEY_SPAN = SITE_SPAN * MAX_DIRS;
	localparam int SETTLE = 12;
	localparam int END_SETTLE = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 250000;
	localparam int PLAN_ROWS = 27;
	localparam int PHASES = 9;

	// request codes the package leaves unnamed
	localparam logic [OPC_W-1:0] OP_QUERY = OPC_W'(2);
	localparam logic [OPC_W-1:0] OP_SPARE = OPC_W'(3);

	typedef struct packed {
		logic [OPC_W-1:0]  op;
		logic [SITE_W-1:0] site;
		logic [DIR_W-1:0]  dir;
	} move_req_t;

	typedef struct packed {
		logic              was;
		logic              present;
		logic [SIZE_W-1:0] size;
		logic              bad;
	} move_res_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CFG_W-1:0] cfg;
		move_req_t        req;
		logic             typed;
		move_res_t        res;
	} plan_row_t;

	localparam move_res_t NO_RES = '0;
	localparam move_req_t NO_REQ = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPC_W-1:0] opcode = '0;
	logic [SITE_W-1:0] site = '0;
	logic [DIR_W-1:0] direction = '0;
	logic out_valid;
	logic out_stall;
	logic was_present;
	logic is_present;
	logic [SIZE_W-1:0] set_size;
	logic bad_direction;

	indexed_move_set_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.site         (site),
		.direction    (direction),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.was_present  (was_present),
		.is_present   (is_present),
		.set_size     (set_size),
		.bad_direction(bad_direction)
	);

	always #4 clk = ~clk;

	// shadow copy of the move set
	logic [12:0]       list_keys [KEY_SPAN];
	logic [SIZE_W-1:0] key_slot [KEY_SPAN];
	bit                key_live [KEY_SPAN];
	int unsigned       live_count = 0;
	logic [CFG_W-1:0]  dirs_cfg = CFG_RESET;

	move_res_t   expected_q [$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          no_idle = 1'b0;
	bit          hold_req = 1'b0;

	// apply one request to the shadow set and give its result
	function automatic move_res_t apply_move(move_req_t r);
		int unsigned dps, key, slot, last;
		move_res_t res;
		dps = (dirs_cfg > MAX_DIRS) ? MAX_DIRS : dirs_cfg;
		res = '0;
		if (r.dir >= dps) begin
			res.size = SIZE_W'(live_count);
			res.bad = 1'b1;
			return res;
		end
		key = (r.site * dps + r.dir) % KEY_SPAN;
		res.was = key_live[key];
		if (r.op == OP_ADD && !key_live[key]) begin
			list_keys[live_count] = 13'(key);
			key_slot[key] = SIZE_W'(live_count);
			key_live[key] = 1'b1;
			live_count++;
		end else if (r.op == OP_REMOVE && key_live[key]) begin
			// last entry moves into the freed slot
			slot = key_slot[key];
			last = list_keys[live_count - 1];
			list_keys[slot] = 13'(last);
			key_slot[last] = SIZE_W'(slot);
			key_live[key] = 1'b0;
			live_count--;
		end
		res.present = key_live[key];
		res.size = SIZE_W'(live_count);
		return res;
	endfunction

	// offer one request, with a random gap in front unless no_idle is set, and log its result
	task automatic send_move(input move_req_t r, input logic typed, input move_res_t typed_res);
		move_res_t pred;
		if (!no_idle) begin
			while ($urandom_range(99) < 19) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		site <= r.site;
		direction <= r.dir;
		do @(posedge clk); while (in_stall);
		pred = apply_move(r);
		expected_q.push_back(typed ? typed_res : pred);
	endtask

	// stop offering until every result is back
	task automatic drain(input int unsigned extra);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_dirs(input logic [CFG_W-1:0] value);
		drain(SETTLE);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		dirs_cfg = value;
		cfg_we <= 1'b0;
	endtask

	task automatic report(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !no_idle && ($urandom_range(99) < 19);
		end
	end

	// result checker
	always @(posedge clk) begin
		move_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				report("was_present", want.was, was_present);
				report("is_present", want.present, is_present);
				report("set_size", want.size, set_size);
				report("bad_direction", want.bad, bad_direction);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		plan_row_t plan [PLAN_ROWS];
		logic [CFG_W-1:0] phase_cfg [PHASES];
		int unsigned phase_len [PHASES];
		move_req_t r;
		int unsigned dps, roll;
		logic [SITE_W-1:0] base;

		plan = '{
			// empty set after reset, redundant removal
			'{ROW_REQ, 4'd0, '{OP_QUERY, 10'd0, 3'd0}, 1'b1, '{1'b0, 1'b0, 14'd0, 1'b0}},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd0, 3'd0}, 1'b1, '{1'b0, 1'b0, 14'd0, 1'b0}},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd0, 3'd0}, 1'b1, '{1'b0, 1'b1, 14'd1, 1'b0}},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd0, 3'd0}, 1'b1, '{1'b1, 1'b1, 14'd1, 1'b0}},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd1023, 3'd3}, 1'b1, '{1'b0, 1'b1, 14'd2, 1'b0}},
			// direction out of range
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd5, 3'd4}, 1'b1, '{1'b0, 1'b0, 14'd2, 1'b1}},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd1023, 3'd7}, 1'b1, '{1'b0, 1'b0, 14'd2, 1'b1}},
			// unused code acts as a query
			'{ROW_REQ, 4'd0, '{OP_SPARE, 10'd1023, 3'd3}, 1'b1, '{1'b1, 1'b1, 14'd2, 1'b0}},
			// swap removals, each from the front of the list, until the list is empty
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd512, 3'd1}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd341, 3'd2}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd0, 3'd0}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_QUERY, 10'd341, 3'd2}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd341, 3'd2}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd512, 3'd1}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd1023, 3'd3}, 1'b1, '{1'b1, 1'b0, 14'd0, 1'b0}},
			// register above the maximum saturates, top key
			'{ROW_CFG, 4'd15, NO_REQ, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd1023, 3'd7}, 1'b1, '{1'b0, 1'b1, 14'd1, 1'b0}},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd0, 3'd7}, 1'b0, NO_RES},
			// zero directions: everything is out of range
			'{ROW_CFG, 4'd0, NO_REQ, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd3, 3'd0}, 1'b1, '{1'b0, 1'b0, 14'd2, 1'b1}},
			'{ROW_CFG, 4'd1, NO_REQ, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_ADD, 10'd1023, 3'd0}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd1023, 3'd1}, 1'b1, '{1'b0, 1'b0, 14'd3, 1'b1}},
			// stored keys survive a register change
			'{ROW_CFG, 4'd8, NO_REQ, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_QUERY, 10'd1023, 3'd7}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_REMOVE, 10'd0, 3'd7}, 1'b0, NO_RES},
			'{ROW_REQ, 4'd0, '{OP_QUERY, 10'd682, 3'd5}, 1'b0, NO_RES}
		};
		phase_cfg = '{4'd2, 4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd4, 4'd7};
		phase_len = '{85, 85, 85, 85, 85, 15, 85, 85, 85};

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_dirs(plan[i].cfg);
			else
				send_move(plan[i].req, plan[i].typed, plan[i].res);
		end

		// random phases, mostly on a small window of sites so moves collide
		for (int p = 0; p < PHASES; p++) begin
			write_dirs(phase_cfg[p]);
			no_idle = (p == 2);
			dps = (phase_cfg[p] > MAX_DIRS) ? MAX_DIRS : phase_cfg[p];
			base = SITE_W'($urandom_range(SITE_SPAN - 8));
			for (int n = 0; n < phase_len[p]; n++) begin
				if (p == 4 && n == 10)
					hold_req = 1'b1;
				if (p == 1 && n == 40)
					drain(0);
				roll = $urandom_range(99);
				if (roll < 40)
					r.op = OP_ADD;
				else if (roll < 72)
					r.op = OP_REMOVE;
				else if (roll < 92)
					r.op = OP_QUERY;
				else
					r.op = OP_SPARE;
				roll = $urandom_range(99);
				if (roll < 60)
					r.site = base + SITE_W'($urandom_range(7));
				else if (roll < 75)
					r.site = $urandom_range(1) ? '1 : '0;
				else
					r.site = SITE_W'($urandom_range(SITE_SPAN - 1));
				if (dps != 0 && $urandom_range(99) < 85)
					r.dir = DIR_W'($urandom_range(dps - 1));
				else
					r.dir = DIR_W'($urandom_range(7));
				send_move(r, 1'b0, NO_RES);
			end
		end
		no_idle = 1'b0;

		// wind down
		drain(END_SETTLE);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
